@@ rtl/mpe_pkg.sv @@
// Shared constants, codes and types of the modular polynomial evaluator.
package mpe_pkg;

  localparam int MAX_TERMS = 64;
  localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int DATA_W    = 31;
  localparam int DEG_W     = 6;
  localparam int MOD_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * MOD_W;
  localparam int MU_W      = MOD_W + 2;
  localparam int NQ_W      = MU_W - 1;
  localparam int T_W       = NQ_W + MU_W;
  localparam int QM_W      = MU_W + MOD_W;
  localparam int R_W       = MOD_W + 2;
  localparam int SHR_W     = $clog2(MOD_W);
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int PIPE_LEN  = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEGREE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = CFG_IDX_W'(1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [DATA_W-1:0] MODULUS_RST  = {DATA_W{1'b1}};
  localparam logic [MOD_W-1:0]  MOD_ZERO_EFF = {1'b1, {DATA_W{1'b0}}};

  typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_RUN, ST_FIN} eval_state_t;
  typedef enum logic [1:0] {RC_IDLE, RC_NORM, RC_DIV} recip_state_t;

  typedef struct packed {
    logic             busy;
    logic [MU_W-1:0]  mu;
    logic [SHR_W-1:0] shr;
  } recip_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] coef;
  } mac_req_t;

endpackage

@@ rtl/mpe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module mpe_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mpe_recip.sv @@
// Modulus normalisation and Barrett reciprocal, one bit per cycle.
module mpe_recip (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mpe_pkg::MOD_W-1:0] m_eff,
  output mpe_pkg::recip_t           rc
);
  import mpe_pkg::*;

  recip_state_t     state_r, state_nxt;
  logic [MOD_W-1:0] mn_r, mn_nxt;
  logic [SHR_W-1:0] sh_r, sh_nxt;
  logic [MOD_W-1:0] rem_r, rem_nxt;
  logic [MU_W-1:0]  mu_r, mu_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_r, 1'b0};
  assign ge      = shifted >= {1'b0, mn_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mn_r  <= mn_nxt;
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    mu_r  <= mu_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mn_nxt    = mn_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    mu_nxt    = mu_r;
    cnt_nxt   = cnt_r;
    if (start) begin
      state_nxt = RC_NORM;
      mn_nxt    = m_eff;
      sh_nxt    = '0;
    end else begin
      unique case (state_r)
        RC_IDLE: begin
        end
        RC_NORM: begin
          if (mn_r[MOD_W-1]) begin
            state_nxt = RC_DIV;
            rem_nxt   = MOD_W'(1);
            mu_nxt    = '0;
            cnt_nxt   = '0;
          end else begin
            mn_nxt = {mn_r[MOD_W-2:0], 1'b0};
            sh_nxt = sh_r + SHR_W'(1);
          end
        end
        RC_DIV: begin
          rem_nxt = ge ? MOD_W'(shifted - {1'b0, mn_r}) : shifted[MOD_W-1:0];
          mu_nxt  = {mu_r[MU_W-2:0], ge};
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_nxt = RC_IDLE;
          end
        end
        default: state_nxt = RC_IDLE;
      endcase
    end
  end

  assign rc.busy = (state_r != RC_IDLE);
  assign rc.mu   = mu_r;
  assign rc.shr  = ~sh_r;

  a_norm_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == RC_DIV |-> mn_r[MOD_W-1])
    else $error("divisor not normalised during division");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == RC_DIV |-> rem_r < mn_r)
    else $error("partial remainder not below divisor");

  a_mu_range: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(rc.busy) |-> mu_r[MU_W-1 -: 2] != 2'b00)
    else $error("reciprocal out of range");

endmodule

@@ rtl/mpe_mac.sv @@
// Six-stage multiply-add with Barrett reduction modulo the effective modulus.
module mpe_mac (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mpe_pkg::mac_req_t          req,
  input  logic [mpe_pkg::MOD_W-1:0]  m_eff,
  input  mpe_pkg::recip_t            rc,
  output logic                       done,
  output logic [mpe_pkg::DATA_W-1:0] res
);
  import mpe_pkg::*;

  localparam int P_W = 2 * DATA_W;

  logic [PIPE_LEN-1:0] vld_r;
  logic [P_W-1:0]      p_r;
  logic [DATA_W-1:0]   c_r;
  logic [PROD_W-1:0]   n_r;
  logic [PROD_W-1:0]   nsh;
  logic [T_W-1:0]      t_r;
  logic [R_W-1:0]      nlo3_r, nlo4_r;
  logic [MU_W-1:0]     q;
  logic [QM_W-1:0]     qm_full;
  logic [R_W-1:0]      qm_r;
  logic [R_W-1:0]      r_r;
  logic [R_W-1:0]      m1, m2, fix;
  logic [DATA_W-1:0]   res_r;

  assign nsh     = n_r >> rc.shr;
  assign q       = t_r[T_W-1 -: MU_W];
  assign qm_full = QM_W'(q) * QM_W'(m_eff);
  assign m1      = R_W'(m_eff);
  assign m2      = R_W'({m_eff, 1'b0});

  always_comb begin
    priority if (r_r >= m2) begin
      fix = r_r - m2;
    end else if (r_r >= m1) begin
      fix = r_r - m1;
    end else begin
      fix = r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LEN-2:0], req.valid};
    end
    p_r    <= P_W'(req.acc) * P_W'(req.x);
    c_r    <= req.coef;
    n_r    <= PROD_W'(p_r) + PROD_W'(c_r);
    t_r    <= T_W'(nsh[NQ_W-1:0]) * T_W'(rc.mu);
    nlo3_r <= n_r[R_W-1:0];
    qm_r   <= qm_full[R_W-1:0];
    nlo4_r <= nlo3_r;
    r_r    <= nlo4_r - qm_r;
    res_r  <= fix[DATA_W-1:0];
  end

  assign done = vld_r[PIPE_LEN-1];
  assign res  = res_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(vld_r))
    else $error("more than one step in the reduction pipeline");

endmodule

@@ rtl/modular_polynomial_eval_core.sv @@
// Top level: modular Horner evaluation over a coefficient memory.
//
//   channel | direction | handshake          | payload
//   in      | sink      | in_valid/in_stall  | in_op, in_data_value
//   out     | source    | out_valid/out_stall| out_residue
//   cfg     | sink      | cfg_we             | cfg_index, cfg_wdata
//
// To evaluate, each coefficient is read from the coefficient RAM port and then passed
// once through the six-stage multiply-reduce unit; the final result is then loaded into
// the output register. After reset and after each modulus write in_stall is held high
// while the reciprocal unit runs. Reset is synchronous and clears the coefficient store
// through per-entry valid flags. A held result does not block loads; a finished
// evaluation waits until the output register is free.
module modular_polynomial_eval_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [mpe_pkg::DATA_W-1:0]    in_data_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mpe_pkg::DATA_W-1:0]    out_residue,
  input  logic                          cfg_we,
  input  logic [mpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpe_pkg::DATA_W-1:0]    cfg_wdata
);
  import mpe_pkg::*;

  logic [DEG_W-1:0]     degree_r;
  logic [DATA_W-1:0]    modulus_r;
  logic                 start_r;
  logic [MOD_W-1:0]     m_eff;
  logic [ADDR_W-1:0]    eff_deg;
  logic [ADDR_W-1:0]    load_pos_r;
  logic [MAX_TERMS-1:0] valid_r;
  eval_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]    idx_r, idx_nxt;
  logic [DATA_W-1:0]    acc_r, acc_nxt;
  logic [DATA_W-1:0]    x_r, x_nxt;
  logic                 coef_vld_r;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_residue_r;
  logic                 out_load;
  logic                 in_xfer;
  logic                 load_xfer;
  logic                 re;
  logic [ADDR_W-1:0]    raddr;
  logic [DATA_W-1:0]    rdata;
  recip_t               rc;
  mac_req_t             mac_req;
  logic                 mac_done;
  logic [DATA_W-1:0]    mac_res;

  assign m_eff = (modulus_r == '0) ? MOD_ZERO_EFF : {1'b0, modulus_r};

  always_comb begin
    if (int'(degree_r) >= MAX_TERMS - 1) begin
      eff_deg = ADDR_W'(MAX_TERMS - 1);
    end else begin
      eff_deg = ADDR_W'(degree_r);
    end
  end

  assign in_stall  = (state_r != ST_IDLE) | start_r | rc.busy;
  assign in_xfer   = in_valid & ~in_stall;
  assign load_xfer = in_xfer & (in_op == OP_LOAD);

  mpe_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TERMS)) u_coef_ram (
    .clk   (clk),
    .we    (load_xfer),
    .waddr (load_pos_r),
    .wdata (in_data_value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  mpe_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .m_eff (m_eff),
    .rc    (rc)
  );

  assign mac_req.valid = (state_r == ST_MAC);
  assign mac_req.acc   = acc_r;
  assign mac_req.x     = x_r;
  assign mac_req.coef  = coef_vld_r ? rdata : '0;

  mpe_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .m_eff (m_eff),
    .rc    (rc),
    .done  (mac_done),
    .res   (mac_res)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    re        = 1'b0;
    raddr     = idx_r - ADDR_W'(1);
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_op == OP_EVAL) begin
          state_nxt = ST_MAC;
          idx_nxt   = eff_deg;
          acc_nxt   = '0;
          x_nxt     = in_data_value;
          re        = 1'b1;
          raddr     = eff_deg;
        end
      end
      ST_MAC: state_nxt = ST_RUN;
      ST_RUN: begin
        if (mac_done) begin
          acc_nxt = mac_res;
          if (idx_r == '0) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt   = idx_r - ADDR_W'(1);
            re        = 1'b1;
            state_nxt = ST_MAC;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      degree_r    <= '0;
      modulus_r   <= MODULUS_RST;
      start_r     <= 1'b1;
      load_pos_r  <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= cfg_we && (cfg_index == REG_MODULUS);
      out_valid_r <= out_load | (out_valid_r & out_stall);
      if (cfg_we) begin
        if (cfg_index == REG_DEGREE) begin
          degree_r <= cfg_wdata[DEG_W-1:0];
        end else if (cfg_index == REG_MODULUS) begin
          modulus_r <= cfg_wdata;
        end
      end
      if (load_xfer) begin
        valid_r[load_pos_r] <= 1'b1;
        load_pos_r <= (load_pos_r >= eff_deg) ? '0 : load_pos_r + ADDR_W'(1);
      end
    end
    idx_r <= idx_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    if (re) begin
      coef_vld_r <= valid_r[raddr];
    end
    if (out_load) begin
      out_residue_r <= acc_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_residue = out_residue_r;

  a_load_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    load_xfer |=> load_pos_r == '0 || load_pos_r == $past(load_pos_r) + ADDR_W'(1))
    else $error("load position did not advance or wrap");

  a_next_term: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && mac_done && idx_r != '0
      |=> state_r == ST_MAC && idx_r == $past(idx_r) - ADDR_W'(1))
    else $error("Horner walk skipped a coefficient");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && !out_stall |=> out_valid_r && out_residue_r == $past(acc_r))
    else $error("finished residue not presented");

endmodule

@@ test/modular_polynomial_eval_core_checker.sv @@
// Channel monitor, Horner residue predictor and result scoreboard for the evaluator.
`timescale 1ns / 100ps
module modular_polynomial_eval_core_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_op,
  input  logic [mpe_pkg::DATA_W-1:0]    in_data_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [mpe_pkg::DATA_W-1:0]    out_residue,
  input  logic                          cfg_we,
  input  logic [mpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpe_pkg::DATA_W-1:0]    cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            checked
);
  import mpe_pkg::*;

  logic [DATA_W-1:0] coef_mem [MAX_TERMS];
  logic [DEG_W-1:0]  next_slot;
  logic [DEG_W-1:0]  deg_reg;
  logic [DATA_W-1:0] mod_reg;
  logic [DATA_W-1:0] expected_residues [$];

  function automatic logic [DATA_W-1:0] horner_residue(input logic [DATA_W-1:0] x);
    logic [63:0] m;
    logic [63:0] xr;
    logic [63:0] acc;
    m   = (mod_reg == '0) ? 64'h8000_0000 : 64'(mod_reg);
    xr  = 64'(x) % m;
    acc = 64'(coef_mem[deg_reg]) % m;
    for (int i = int'(deg_reg) - 1; i >= 0; i--)
      acc = (acc * xr + 64'(coef_mem[i]) % m) % m;
    return acc[DATA_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [DATA_W-1:0] want;
    if (!rst_n) begin
      foreach (coef_mem[i]) coef_mem[i] = '0;
      next_slot = '0;
      deg_reg   = '0;
      mod_reg   = MODULUS_RST;
      expected_residues.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEGREE:  deg_reg = cfg_wdata[DEG_W-1:0];
          REG_MODULUS: mod_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_residues.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: residue %0d with no evaluation outstanding", $time, out_residue);
          fail_count++;
        end else begin
          want = expected_residues.pop_front();
          checked++;
          if (out_residue !== want) begin
            if (fail_count < 10)
              $display("%0t: residue mismatch, expected %0d, got %0d",
                       $time, want, out_residue);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_op == OP_LOAD) begin
          coef_mem[next_slot] = in_data_value;
          next_slot = (next_slot >= deg_reg) ? '0 : next_slot + 1'b1;
        end else begin
          expected_residues.push_back(horner_residue(in_data_value));
        end
      end
    end
    pending = expected_residues.size();
  end

endmodule

@@ test/modular_polynomial_eval_core_test.sv @@
// Testbench top: clock, reset, coefficient and point stimulus, register settings, verdict.
`timescale 1ns / 100ps
module modular_polynomial_eval_core_test;
  import mpe_pkg::*;

  localparam int ITEMS          = 1350;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 700;
  localparam int DRAIN_CYCLES   = 8;
  localparam int TAIL_CYCLES    = 7 * MAX_TERMS + 50;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);
  localparam logic [DATA_W-1:0]    ALL_ONES     = {DATA_W{1'b1}};

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic                 in_op         = OP_LOAD;
  logic [DATA_W-1:0]    in_data_value = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [DATA_W-1:0]    out_residue;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = REG_DEGREE;
  logic [DATA_W-1:0]    cfg_wdata     = '0;

  int fail_count;
  int pending;
  int checked;
  int loads_sent;
  int evals_sent;
  int settings_used;
  int burst_left;
  int idle_cycles;
  int hold_asked;
  int hold_seen;
  int hold_left;
  int pattern_left;
  int stall_pct;

  always #6 clk = ~clk;

  modular_polynomial_eval_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_data_value (in_data_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_residue   (out_residue),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  modular_polynomial_eval_core_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_data_value (in_data_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_residue   (out_residue),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked)
  );

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return ALL_ONES;
      2: return DATA_W'($urandom_range(15));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [DATA_W-1:0] value);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_data_value <= value;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (op == OP_LOAD) loads_sent++;
    else evals_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic configure(input logic [DEG_W-1:0] deg, input logic [DATA_W-1:0] modv,
                           input bit spare);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [DATA_W-1:0]    dat [4];
    int                   n;
    idx[0] = REG_DEGREE;
    dat[0] = DATA_W'($urandom);
    dat[0][DEG_W-1:0] = deg;
    idx[1] = REG_MODULUS;
    dat[1] = modv;
    idx[2] = REG_SPARE_LO;
    dat[2] = DATA_W'($urandom);
    idx[3] = REG_SPARE_HI;
    dat[3] = DATA_W'($urandom);
    n = spare ? 4 : 2;
    for (int k = 0; k < n; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= dat[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 300);
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      pattern_left--;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("modular_polynomial_eval_core test failed");
      $finish;
    end
  end

  initial begin
    logic [DEG_W-1:0]  deg;
    logic [DATA_W-1:0] modv;
    int                phase;
    int                phase_end;
    phase = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // freshly cleared store
    send_item(OP_EVAL, ALL_ONES);

    settle();
    configure(DEG_W'(3), ALL_ONES, 1'b1);
    send_item(OP_LOAD, ALL_ONES);
    send_item(OP_LOAD, '0);
    send_item(OP_LOAD, ALL_ONES - 1'b1);
    send_item(OP_LOAD, DATA_W'(1));
    send_item(OP_EVAL, ALL_ONES);
    send_item(OP_EVAL, ALL_ONES - 1'b1);
    send_item(OP_EVAL, DATA_W'(1));
    send_item(OP_EVAL, '0);
    // load position wraps back to the constant term
    send_item(OP_LOAD, DATA_W'('h1234_5678));
    send_item(OP_EVAL, DATA_W'(2));
    send_item(OP_LOAD, DATA_W'(5));
    send_item(OP_LOAD, DATA_W'(6));

    // lower the degree below the load position
    settle();
    configure(DEG_W'(1), DATA_W'(1000003), 1'b0);
    send_item(OP_LOAD, DATA_W'('h5555_5555));
    send_item(OP_LOAD, DATA_W'(7));
    send_item(OP_EVAL, DATA_W'('h2AAA_AAAA));

    // zero modulus wraps at 2^31
    settle();
    configure(DEG_W'(2), '0, 1'b0);
    send_item(OP_EVAL, ALL_ONES);
    send_item(OP_EVAL, DATA_W'('h4000_0000));

    settle();
    configure(DEG_W'(63), DATA_W'(1), 1'b0);
    send_item(OP_EVAL, ALL_ONES);

    settle();
    configure(DEG_W'(0), DATA_W'(2), 1'b0);
    send_item(OP_LOAD, ALL_ONES);
    send_item(OP_EVAL, DATA_W'('h5555_5555));

    while (loads_sent + evals_sent < ITEMS) begin
      settle();
      case ($urandom_range(9))
        0: deg = DEG_W'(63);
        1, 2: deg = DEG_W'($urandom_range(8, 63));
        default: deg = DEG_W'($urandom_range(7));
      endcase
      case ($urandom_range(7))
        0: modv = '0;
        1: modv = DATA_W'($urandom_range(1, 2));
        2: modv = ALL_ONES;
        3: modv = ALL_ONES - 1'b1;
        4, 5: modv = DATA_W'($urandom_range(3, 1000));
        default: modv = DATA_W'($urandom);
      endcase
      configure(deg, modv, $urandom_range(3) == 0);
      if (phase == 0 || phase == 9) hold_asked++;
      phase_end = loads_sent + evals_sent + $urandom_range(40, 90);
      while (loads_sent + evals_sent < phase_end) begin
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 6))
            send_item($urandom_range(1) ? OP_EVAL : OP_LOAD, pick_value());
        end else begin
          repeat (int'(deg) + 1) send_item(OP_LOAD, pick_value());
          repeat ($urandom_range(1, 4)) send_item(OP_EVAL, pick_value());
        end
      end
      phase++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d coefficient loads and %0d evaluations across %0d register settings,",
             loads_sent, evals_sent, settings_used);
    $display("with %0d residues compared against the predicted values.", checked);
    if (fail_count == 0 && pending == 0)
      $display("modular_polynomial_eval_core test passed");
    else
      $display("modular_polynomial_eval_core test failed");
    $finish;
  end

endmodule
